[rtl/tsw_pkg.sv]
// constants, types and helpers for the thinning subpass window
// shared by thinning_subpass_window and its testbench; no dependencies

package tsw_pkg;

  // configuration port
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SUBPASS      = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] DEF_DIM = 12'd64;

  // parameter defaults
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;

  // stream words
  localparam int unsigned TDATA_W = 8;

  // removal thresholds
  localparam logic [3:0] MIN_SET      = 4'd2;
  localparam logic [3:0] MAX_SET      = 4'd6;
  localparam logic [3:0] RING_CHANGES = 4'd2;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic has_result;
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
    logic frame_last;
  } item_flags_t;

  // register value to effective dimension: 0 acts as 1, above max acts as max
  function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    logic [31:0] ext;
    ext = {{(32-CFG_W){1'b0}}, v};
    if (ext == 32'd0) return 32'd1;
    if (ext > maxv) return maxv;
    return ext;
  endfunction

endpackage

[rtl/thinning_subpass_window.sv]
// thinning_subpass_window: one zhang-suen thinning subpass over a streamed binary image
// depends on tsw_pkg; holds the line memory, 3x3 window and output register
//
// Pixels enter one word per clock in raster order, kind 0 for image pixels and
// kind 1 for drain ticks; after a frame send image_width+1 drain words to flush
// the last results. The block takes one word every clock as long as results are
// taken; a 2-bit wide line memory indexed by column (one read and one write per
// clock) feeds a 3x3 window, so the result for pixel m passes through stage 1,
// the window stage and the output register once word m+width+1 is accepted.
// Pixels outside the image count as 0. The last result of a frame carries tlast
// and the frame changed flag, after which counters restart for the next frame.
// Any write to a defined register restarts the frame; write registers only while idle.

module thinning_subpass_window
  import tsw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // pixel input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,  // [0] pixel_in, [7:1] zero
  input  logic                 s_axis_tuser,  // [0] kind
  // result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,  // [0] pixel_out, [1] removed,
                                              // [2] frame_changed, [7:3] zero
  output logic                 m_axis_tlast   // last
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned LIM_W = $clog2(MAX_WIDTH + 2);

  // configuration registers, held as effective dimensions
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [LIM_W-1:0] wlim;
  logic             subpass;
  logic             restart;

  logic [31:0] cfg_dim;
  assign cfg_dim = clamp_dim(cfg_data, (cfg_index == REG_IMAGE_WIDTH) ? MAX_WIDTH : MAX_HEIGHT);

  // a write to a defined register restarts the frame at the same edge
  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
                              || cfg_index == REG_SUBPASS);

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1     <= COL_W'(clamp_dim(DEF_DIM, MAX_WIDTH) - 32'd1);
      wlim    <= LIM_W'(clamp_dim(DEF_DIM, MAX_WIDTH) + 32'd1);
      hm1     <= ROW_W'(clamp_dim(DEF_DIM, MAX_HEIGHT) - 32'd1);
      subpass <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            wm1     <= COL_W'(cfg_dim - 32'd1);
            wlim    <= LIM_W'(cfg_dim + 32'd1);
          end
          REG_IMAGE_HEIGHT: begin
            hm1     <= ROW_W'(cfg_dim - 32'd1);
          end
          REG_SUBPASS: begin
            subpass <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pipeline handshake
  logic s1_valid, s2_valid, out_valid;
  logic out_free, s2_can, s1_go, accept, out_load;

  assign out_free      = !out_valid || m_axis_tready;
  assign s2_can        = !s2_valid || out_free;
  assign s1_go         = s1_valid && s2_can;
  assign s_axis_tready = !s1_valid || s2_can;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = s2_valid && out_free;

  // input position counters
  logic [COL_W-1:0] in_col, in_col_next;
  logic [LIM_W-1:0] pre_cnt, pre_cnt_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  item_flags_t      in_flags;
  logic             in_bit;

  assign in_bit = !s_axis_tuser && s_axis_tdata[0];

  always_comb begin
    in_flags.has_result = (pre_cnt == wlim);
    in_flags.first_row  = (out_row == '0);
    in_flags.last_row   = (out_row == hm1);
    in_flags.first_col  = (out_col == '0);
    in_flags.last_col   = (out_col == wm1);
    in_flags.frame_last = in_flags.has_result && in_flags.last_row && in_flags.last_col;

    in_col_next  = (in_col == wm1) ? '0 : in_col + 1'b1;
    pre_cnt_next = in_flags.has_result ? pre_cnt : pre_cnt + 1'b1;
    out_col_next = out_col;
    out_row_next = out_row;
    if (in_flags.has_result) begin
      if (in_flags.last_col) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
    // frame end: next word starts a new frame
    if (in_flags.frame_last) begin
      in_col_next  = '0;
      pre_cnt_next = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      pre_cnt <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      in_col  <= in_col_next;
      pre_cnt <= pre_cnt_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // stage 1: accepted word and its line memory read
  logic             s1_bit;
  logic [COL_W-1:0] s1_col;
  item_flags_t      s1_flags;
  logic [1:0]       rd;       // [0] one row up, [1] two rows up
  logic [1:0]       wr_data;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bit   <= in_bit;
      s1_col   <= in_col;
      s1_flags <= in_flags;
    end
  end

  // line memory: each column holds the pixels one and two rows up
  logic [1:0] line_mem [MAX_WIDTH];

  assign wr_data = {rd[0], s1_bit};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  // forward the word being written when a one-pixel row reads it back at once
  always_ff @(posedge clk) begin
    if (accept) begin
      if (s1_go && s1_col == in_col) begin
        rd <= wr_data;
      end else begin
        rd <= line_mem[in_col];
      end
    end
  end

  // stage 2: 3x3 window, column 0 newest (east side)
  logic [2:0]  win_top, win_mid, win_bot;
  item_flags_t s2_flags;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= s1_flags.has_result;
    end else if (out_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_top  <= {win_top[1:0], rd[1]};
      win_mid  <= {win_mid[1:0], rd[0]};
      win_bot  <= {win_bot[1:0], s1_bit};
      s2_flags <= s1_flags;
    end
  end

  // neighbour ring from north clockwise, zero outside the image
  logic [7:0] nb;
  logic       centre, dir_ok, remove;
  logic [3:0] set_cnt, chg_cnt;

  always_comb begin
    nb[0] = win_top[1] && !s2_flags.first_row;                          // n
    nb[1] = win_top[0] && !s2_flags.first_row && !s2_flags.last_col;    // ne
    nb[2] = win_mid[0] && !s2_flags.last_col;                           // e
    nb[3] = win_bot[0] && !s2_flags.last_row && !s2_flags.last_col;     // se
    nb[4] = win_bot[1] && !s2_flags.last_row;                           // s
    nb[5] = win_bot[2] && !s2_flags.last_row && !s2_flags.first_col;    // sw
    nb[6] = win_mid[2] && !s2_flags.first_col;                          // w
    nb[7] = win_top[2] && !s2_flags.first_row && !s2_flags.first_col;   // nw
    centre = win_mid[1];
    set_cnt = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
            + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
    chg_cnt = 4'(nb[0] ^ nb[1]) + 4'(nb[1] ^ nb[2]) + 4'(nb[2] ^ nb[3])
            + 4'(nb[3] ^ nb[4]) + 4'(nb[4] ^ nb[5]) + 4'(nb[5] ^ nb[6])
            + 4'(nb[6] ^ nb[7]) + 4'(nb[7] ^ nb[0]);
    if (subpass) begin
      dir_ok = !nb[2] || !nb[4] || (!nb[0] && !nb[6]);
    end else begin
      dir_ok = !nb[0] || !nb[6] || (!nb[2] && !nb[4]);
    end
    remove = centre && (set_cnt >= MIN_SET) && (set_cnt <= MAX_SET)
          && (chg_cnt == RING_CHANGES) && dir_ok;
  end

  // output register and frame change flag
  logic any_removed;
  logic pixel_out, removed, frame_changed, last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid   <= 1'b0;
      any_removed <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid   <= 1'b1;
        any_removed <= s2_flags.frame_last ? 1'b0 : (any_removed || remove);
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out     <= centre && !remove;
      removed       <= remove;
      last          <= s2_flags.frame_last;
      frame_changed <= s2_flags.frame_last && (any_removed || remove);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TDATA_W-3){1'b0}}, frame_changed, removed, pixel_out};
  assign m_axis_tlast  = last;

  // checks
  a_removed_clears: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("removed pixel still set");

  a_changed_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tlast)
    else $error("frame changed flag away from last result");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_can |-> !s_axis_tready)
    else $error("word accepted over a stalled stage");

  a_counters_range: assert property (@(posedge clk) disable iff (rst)
    in_col <= wm1 && out_col <= wm1 && out_row <= hm1 && pre_cnt <= wlim)
    else $error("position counter out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst || restart)
    s1_go && s1_flags.has_result |=> s2_valid)
    else $error("result lost between window and output");

endmodule

[dv/thinning_subpass_window_test.sv]
// testbench for thinning_subpass_window: streams binary frames and checks every result word
// against a zhang-suen subpass predictor kept in step with each accepted word
// depends on tsw_pkg and thinning_subpass_window

module thinning_subpass_window_test;
  import tsw_pkg::*;

  localparam int unsigned RING_LEN      = 2 * DEF_MAX_WIDTH + 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic KIND_PIXEL           = 1'b0;
  localparam logic KIND_DRAIN           = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS  = 400;

  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic last;
    logic frame_changed;
  } thin_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;  // [0] pixel_in, [7:1] zero
  logic               s_axis_tuser = 1'b0;  // [0] kind
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;  // [0] pixel_out, [1] removed, [2] frame_changed
  logic               m_axis_tlast;

  // predictor state
  logic             ring [RING_LEN];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             subpass_reg;
  int unsigned      dec_col;
  int unsigned      dec_row;
  int unsigned      dec_index;
  int unsigned      words_taken;
  logic             any_cleared;
  thin_result_t     expected_pixels [$];

  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left  = 0;
  bit          steady      = 1'b0;

  always #5 clk = ~clk;

  thinning_subpass_window #(
    .MAX_WIDTH (DEF_MAX_WIDTH),
    .MAX_HEIGHT(DEF_MAX_HEIGHT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // register value to working size: 0 means 1, oversize means the maximum
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_pixels();
    return eff_dim(width_reg, DEF_MAX_WIDTH) * eff_dim(height_reg, DEF_MAX_HEIGHT);
  endfunction

  function automatic int unsigned frame_words();
    return frame_pixels() + eff_dim(width_reg, DEF_MAX_WIDTH) + 1;
  endfunction

  function automatic void thin_restart();
    dec_col     = 0;
    dec_row     = 0;
    dec_index   = 0;
    words_taken = 0;
    any_cleared = 1'b0;
  endfunction

  // neighbour of the pixel being decided; outside the image reads as 0
  function automatic logic nbr_pixel(input int dr, input int dc,
                                     input int unsigned w, input int unsigned h);
    int r;
    int c;
    r = int'(dec_row) + dr;
    c = int'(dec_col) + dc;
    if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) return 1'b0;
    return ring[(r * int'(w) + c) % RING_LEN];
  endfunction

  // take one accepted word; queue the decision it releases, if any
  function automatic void thin_take(input logic kind, input logic pix);
    int unsigned  w;
    int unsigned  h;
    int unsigned  total;
    int unsigned  set_cnt;
    int unsigned  changes;
    int           k;
    logic         centre;
    logic         dir_ok;
    logic         clear;
    logic         is_last;
    logic [7:0]   nb;  // n, ne, e, se, s, sw, w, nw from bit 0
    thin_result_t res;
    w = eff_dim(width_reg, DEF_MAX_WIDTH);
    h = eff_dim(height_reg, DEF_MAX_HEIGHT);
    total = w * h;
    if (words_taken < total) ring[words_taken % RING_LEN] = (kind == KIND_PIXEL) ? pix : 1'b0;
    words_taken++;
    if (words_taken < w + 2) return;
    centre = nbr_pixel(0, 0, w, h);
    nb[0] = nbr_pixel(-1, 0, w, h);
    nb[1] = nbr_pixel(-1, 1, w, h);
    nb[2] = nbr_pixel(0, 1, w, h);
    nb[3] = nbr_pixel(1, 1, w, h);
    nb[4] = nbr_pixel(1, 0, w, h);
    nb[5] = nbr_pixel(1, -1, w, h);
    nb[6] = nbr_pixel(0, -1, w, h);
    nb[7] = nbr_pixel(-1, -1, w, h);
    set_cnt = 0;
    changes = 0;
    for (k = 0; k < 8; k++) begin
      set_cnt += nb[k];
      if (nb[k] != nb[(k + 1) % 8]) changes++;
    end
    // directional test: east/south form or north/west form
    if (subpass_reg)
      dir_ok = !nb[2] || !nb[4] || (!nb[0] && !nb[6]);
    else
      dir_ok = !nb[0] || !nb[6] || (!nb[2] && !nb[4]);
    clear = centre && set_cnt >= MIN_SET && set_cnt <= MAX_SET &&
            changes == RING_CHANGES && dir_ok;
    any_cleared |= clear;
    is_last = (dec_index + 1 >= total);
    res.pixel_out     = clear ? 1'b0 : centre;
    res.removed       = clear;
    res.last          = is_last;
    res.frame_changed = is_last ? any_cleared : 1'b0;
    expected_pixels.push_back(res);
    if (is_last) begin
      thin_restart();
    end else begin
      dec_index++;
      dec_col++;
      if (dec_col >= w) begin
        dec_col = 0;
        dec_row++;
      end
    end
  endfunction

  function automatic void compare_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(13, 24));
    return CFG_W'($urandom_range(1, 10));
  endfunction

  // input and output monitor: check results, then feed accepted words to the predictor
  always @(posedge clk) begin
    thin_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual tdata=%h tlast=%b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          compare_bit("pixel_out", want.pixel_out, m_axis_tdata[0]);
          compare_bit("removed", want.removed, m_axis_tdata[1]);
          compare_bit("frame_changed", want.frame_changed, m_axis_tdata[2]);
          compare_bit("last", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) thin_take(s_axis_tuser, s_axis_tdata[0]);
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = value;
        thin_restart();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = value;
        thin_restart();
      end
      REG_SUBPASS: begin
        subpass_reg = value[0];
        thin_restart();
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one word, after a random gap unless running steady
  task automatic send_word(input logic kind, input logic pix);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-1){1'b0}}, pix};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and wait until every expected word is out and the pipe is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pixels at the given density, then drain ticks; noisy frames mix in early
  // drains and use surplus pixels as drains
  task automatic send_frame(input int unsigned words, input int unsigned density,
                            input bit noisy);
    int unsigned total;
    int unsigned p;
    logic        kind;
    logic        pix;
    total = frame_pixels();
    for (p = 0; p < words; p++) begin
      if (p < total) begin
        kind = (noisy && $urandom_range(0, 7) == 0) ? KIND_DRAIN : KIND_PIXEL;
        pix  = ($urandom_range(0, 99) < density);
      end else begin
        kind = (noisy && $urandom_range(0, 1) == 0) ? KIND_PIXEL : KIND_DRAIN;
        pix  = $urandom_range(0, 1);
      end
      send_word(kind, pix);
    end
  endtask

  // partial frame at the reset size and subpass
  task automatic test_reset_values();
    send_frame(80, 60, 1'b0);
    settle();
  endtask

  // solid blocks: corners and some edge pixels go, the centre of the square stays; both subpasses
  task automatic test_solid_square();
    int i;
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    write_reg(REG_SUBPASS, 12'd0);
    for (i = 0; i < 9; i++) send_word(KIND_PIXEL, 1'b1);
    for (i = 0; i < 4; i++) send_word(KIND_DRAIN, 1'b1);
    settle();
    write_reg(REG_SUBPASS, 12'd1);
    write_reg(REG_IMAGE_HEIGHT, 12'd2);
    for (i = 0; i < 6; i++) send_word(KIND_PIXEL, 1'b1);
    // surplus pixels flush the frame like drain ticks
    for (i = 0; i < 4; i++) send_word(KIND_PIXEL, 1'b1);
    settle();
  endtask

  // a drain tick inside the frame acts as a cleared pixel
  task automatic test_early_drain();
    int i;
    write_reg(REG_IMAGE_WIDTH, 12'd2);
    write_reg(REG_IMAGE_HEIGHT, 12'd2);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_DRAIN, 1'b1);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_PIXEL, 1'b1);
    for (i = 0; i < 3; i++) send_word(KIND_DRAIN, i[0]);
    settle();
  endtask

  // zero sizes act as a single pixel; back to back frames with no write
  task automatic test_tiny_frame();
    write_reg(REG_IMAGE_WIDTH, 12'd0);
    write_reg(REG_IMAGE_HEIGHT, 12'd0);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_DRAIN, 1'b1);
    send_word(KIND_DRAIN, 1'b0);
    send_word(KIND_PIXEL, 1'b0);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_DRAIN, 1'b1);
    settle();
  endtask

  // oversize values clamp to the maximum; the frame is cut short and then
  // restarted by the next register write
  task automatic test_wide_partial();
    write_reg(REG_IMAGE_WIDTH, 12'hfff);
    write_reg(REG_IMAGE_HEIGHT, 12'hfff);
    write_reg(REG_SUBPASS, 12'd1);
    send_frame(DEF_MAX_WIDTH + 8, 70, 1'b0);
    settle();
  endtask

  // one pixel wide, many rows
  task automatic test_tall_frame();
    write_reg(REG_IMAGE_WIDTH, 12'd0);
    write_reg(REG_IMAGE_HEIGHT, 12'd40);
    write_reg(REG_SUBPASS, 12'd0);
    send_frame(frame_words(), 50, 1'b0);
    settle();
  endtask

  // random sizes, subpasses and densities; a few noisy or cut-short frames
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned words;
    int unsigned first;
    int          k;
    bit          noisy;
    bit          must_write;
    logic [CFG_IDX_W-1:0] slot;
    sent = 0;
    must_write = 1'b1;
    while (sent < RANDOM_WORDS) begin
      if (must_write || $urandom_range(0, 4) < 3) begin
        settle();
        steady = ($urandom_range(0, 3) == 0);
        first = $urandom_range(0, 2);
        for (k = 0; k < 3; k++) begin
          slot = CFG_IDX_W'((first + k) % 3);
          if ($urandom_range(0, 3) != 0) begin
            case (slot)
              REG_IMAGE_WIDTH:  write_reg(slot, pick_dim());
              REG_IMAGE_HEIGHT: write_reg(slot, pick_dim());
              default:          write_reg(slot, CFG_W'($urandom_range(0, 1)));
            endcase
          end
        end
        if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 4095)));
        must_write = 1'b0;
      end
      noisy = ($urandom_range(0, 9) == 0);
      words = frame_words();
      if ($urandom_range(0, 9) == 0) begin
        words = $urandom_range(1, words - 1);
        must_write = 1'b1;
      end
      send_frame(words, 20 + 20 * $urandom_range(0, 4), noisy);
      sent += words;
    end
    settle();
  endtask

  initial begin
    width_reg   = DEF_DIM;
    height_reg  = DEF_DIM;
    subpass_reg = 1'b0;
    foreach (ring[i]) ring[i] = 1'b0;
    thin_restart();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_solid_square();
    test_early_drain();
    test_tiny_frame();
    test_wide_partial();
    test_tall_frame();
    test_random_frames();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
